/* hw/rtl/dash_can_safety_monitor_assert.svh */
// Assertion macros shared by the dashboard CAN safety monitor RTL.
`ifndef DASH_CAN_SAFETY_MONITOR_ASSERT_SVH
`define DASH_CAN_SAFETY_MONITOR_ASSERT_SVH

`ifndef ASSERT_OFF
// Checked property with the assertion switched off while reset is high.
`define DCSM_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked property that also holds through reset.
`define DCSM_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DCSM_ASSERT_RST(label, clk, rst, prop, msg)
`define DCSM_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

/* hw/rtl/dcsm_pkg.sv */
// Types and constants shared by the dashboard CAN safety monitor modules.
`timescale 1ns / 1ps
package dcsm_pkg;

   // Item kinds on the request channel
   localparam logic REQ_FRAME = 1'b0;
   localparam logic REQ_TICK  = 1'b1;

   // CAN identifiers that the monitor reacts to
   localparam logic [10:0] ID_PRECHARGE = 11'h008;
   localparam logic [10:0] ID_RELAY     = 11'h009;
   localparam logic [10:0] ID_BATTERY   = 11'h00A;
   localparam logic [10:0] ID_LOGGING   = 11'h101;
   localparam logic [10:0] ID_LIMIT     = 11'h6B1;
   localparam logic [10:0] ID_MOTOR1    = 11'h7A1;
   localparam logic [10:0] ID_MOTOR2    = 11'h7A2;
   localparam logic [10:0] ID_STATUS    = 11'h7A4;

   // Screen codes
   localparam logic [1:0] SCREEN_NORMAL   = 2'd0;
   localparam logic [1:0] SCREEN_FAULT    = 2'd1;
   localparam logic [1:0] SCREEN_IGNITION = 2'd2;

   // Configuration register indexes
   localparam logic [1:0] CSR_TIMEOUT   = 2'd0;
   localparam logic [1:0] CSR_PRELIGHT  = 2'd1;
   localparam logic [1:0] CSR_HOLD      = 2'd2;
   localparam logic [1:0] CSR_TX_PERIOD = 2'd3;

   // Reset values of the configuration registers and telemetry
   localparam logic [15:0] TIMEOUT_RESET   = 16'd10000;
   localparam logic [15:0] PRELIGHT_RESET  = 16'd3000;
   localparam logic [15:0] HOLD_RESET      = 16'd2500;
   localparam logic [15:0] TX_PERIOD_RESET = 16'd100;
   localparam logic [7:0]  CHARGE_RESET    = 8'd100;
   localparam logic [15:0] LIMIT_RESET     = 16'd1;

   typedef struct packed {
      logic        req_type;
      logic [10:0] frame_id;
      logic [63:0] frame_data;
      logic        rtd_pin;
      logic        button_pin;
   } req_item_type;

   typedef struct packed {
      logic        fault_light;
      logic        rtd_state;
      logic        button_toggle;
      logic        tx_request;
      logic [1:0]  screen_select;
      logic        precharge_on;
      logic        logging_on;
      logic [7:0]  pack_temp;
      logic [7:0]  pack_charge;
      logic [6:0]  max_motor_temp;
      logic [15:0] min_motor_voltage;
      logic [15:0] discharge_limit;
   } rsp_item_type;

   typedef struct packed {
      logic        we;
      logic [1:0]  index;
      logic [15:0] data;
   } csr_write_type;

   // Post-update view of the frame-driven state
   typedef struct packed {
      logic        precharge_on;
      logic        logging_on;
      logic        status_fault;
      logic [7:0]  pack_temp;
      logic [7:0]  pack_charge;
      logic [6:0]  max_motor_temp;
      logic [15:0] min_motor_voltage;
      logic [15:0] discharge_limit;
   } telem_out_type;

   // Post-update view of the light, switch and button state
   typedef struct packed {
      logic fault_light;
      logic rtd_state;
      logic button_toggle;
      logic tx_request;
      logic hold_started;
   } safety_out_type;

endpackage

/* hw/rtl/dcsm_telemetry.sv */
// Frame dispatch by identifier and the telemetry and flag registers it updates.
`timescale 1ns / 1ps
module dcsm_telemetry (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  dcsm_pkg::req_item_type item,
   output dcsm_pkg::telem_out_type telem
);

   logic        precharge_ff, precharge_in;
   logic        logging_ff, logging_in;
   logic        status_fault_ff, status_fault_in;
   logic [7:0]  btemp_ff, btemp_in;
   logic [7:0]  bcharge_ff, bcharge_in;
   logic [6:0]  mtemp1_ff, mtemp1_in;
   logic [6:0]  mtemp2_ff, mtemp2_in;
   logic [15:0] mvolt1_ff, mvolt1_in;
   logic [15:0] mvolt2_ff, mvolt2_in;
   logic [15:0] limit_ff, limit_in;

   logic [63:0] d;

   assign d = item.frame_data;

   always_comb begin
      precharge_in    = precharge_ff;
      logging_in      = logging_ff;
      status_fault_in = status_fault_ff;
      btemp_in        = btemp_ff;
      bcharge_in      = bcharge_ff;
      mtemp1_in       = mtemp1_ff;
      mtemp2_in       = mtemp2_ff;
      mvolt1_in       = mvolt1_ff;
      mvolt2_in       = mvolt2_ff;
      limit_in        = limit_ff;
      if (item.req_type == dcsm_pkg::REQ_FRAME) begin
         unique case (item.frame_id) inside
            dcsm_pkg::ID_PRECHARGE: begin
               precharge_in = (d[7:0] == 8'd1);
            end
            dcsm_pkg::ID_BATTERY: begin
               btemp_in   = d[15:8];
               bcharge_in = d[31:24];
            end
            dcsm_pkg::ID_LOGGING: begin
               logging_in = 1'b1;
            end
            dcsm_pkg::ID_LIMIT: begin
               limit_in = {d[7:0], d[15:8]};
            end
            dcsm_pkg::ID_MOTOR1, dcsm_pkg::ID_MOTOR2: begin
               if (item.frame_id == dcsm_pkg::ID_MOTOR1) begin
                  mtemp1_in = d[7:1];
                  mvolt1_in = {d[39:32], d[47:40]};
               end else begin
                  mtemp2_in = d[7:1];
                  mvolt2_in = {d[39:32], d[47:40]};
               end
            end
            dcsm_pkg::ID_STATUS: begin
               // Any non-zero byte among the first five flags a fault.
               status_fault_in = |d[39:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         precharge_ff    <= 1'b0;
         logging_ff      <= 1'b0;
         status_fault_ff <= 1'b0;
         btemp_ff        <= 8'd0;
         bcharge_ff      <= dcsm_pkg::CHARGE_RESET;
         mtemp1_ff       <= 7'd0;
         mtemp2_ff       <= 7'd0;
         mvolt1_ff       <= 16'd0;
         mvolt2_ff       <= 16'd0;
         limit_ff        <= dcsm_pkg::LIMIT_RESET;
      end else if (step) begin
         precharge_ff    <= precharge_in;
         logging_ff      <= logging_in;
         status_fault_ff <= status_fault_in;
         btemp_ff        <= btemp_in;
         bcharge_ff      <= bcharge_in;
         mtemp1_ff       <= mtemp1_in;
         mtemp2_ff       <= mtemp2_in;
         mvolt1_ff       <= mvolt1_in;
         mvolt2_ff       <= mvolt2_in;
         limit_ff        <= limit_in;
      end
   end

   always_comb begin
      telem.precharge_on      = precharge_in;
      telem.logging_on        = logging_in;
      telem.status_fault      = status_fault_in;
      telem.pack_temp         = btemp_in;
      telem.pack_charge       = bcharge_in;
      telem.max_motor_temp    = (mtemp1_in > mtemp2_in) ? mtemp1_in : mtemp2_in;
      telem.min_motor_voltage = (mvolt1_in < mvolt2_in) ? mvolt1_in : mvolt2_in;
      telem.discharge_limit   = limit_in;
   end

endmodule

/* hw/rtl/dcsm_safety.sv */
// Fault light timing, relay watchdog, button hold logic, transmit timer and settings.
`timescale 1ns / 1ps
`include "dash_can_safety_monitor_assert.svh"
module dcsm_safety (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  dcsm_pkg::req_item_type  item,
   input  dcsm_pkg::csr_write_type csr,
   output dcsm_pkg::safety_out_type safety
);

   logic [15:0] timeout_ff, prelight_ff, hold_ms_ff, tx_period_ff;

   logic        armed_ff, armed_in;
   logic        light_on_ff, light_on_in;
   logic [15:0] prelight_count_ff, prelight_count_in;
   logic [15:0] silence_count_ff, silence_count_in;
   logic [15:0] tx_count_ff, tx_count_in;
   logic [15:0] hold_count_ff, hold_count_in;
   logic        hold_started_ff, hold_started_in;
   logic        wait_release_ff, wait_release_in;
   logic        toggle_ff, toggle_in;
   logic        rtd_ff, rtd_in;
   logic        tx_req;

   function automatic logic [15:0] sat_inc(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   always_comb begin
      armed_in          = armed_ff;
      light_on_in       = light_on_ff;
      prelight_count_in = prelight_count_ff;
      silence_count_in  = silence_count_ff;
      tx_count_in       = tx_count_ff;
      hold_count_in     = hold_count_ff;
      hold_started_in   = hold_started_ff;
      wait_release_in   = wait_release_ff;
      toggle_in         = toggle_ff;
      rtd_in            = rtd_ff;
      tx_req            = 1'b0;
      if (item.req_type == dcsm_pkg::REQ_TICK) begin
         silence_count_in = sat_inc(silence_count_ff);
         tx_count_in      = sat_inc(tx_count_ff);
         hold_count_in    = sat_inc(hold_count_ff);
         if (!armed_ff) begin
            prelight_count_in = sat_inc(prelight_count_ff);
            if (prelight_count_in >= prelight_ff) begin
               armed_in         = 1'b1;
               light_on_in      = 1'b0;
               silence_count_in = 16'd0;
            end
         end
         if (armed_in && !light_on_in && (silence_count_in > timeout_ff)) begin
            light_on_in = 1'b1;
         end
         rtd_in = item.rtd_pin;
         if (item.button_pin && !wait_release_ff) begin
            if (!hold_started_ff) begin
               hold_started_in = 1'b1;
               hold_count_in   = 16'd0;
            end else if (hold_count_in > hold_ms_ff) begin
               toggle_in       = ~toggle_ff;
               tx_req          = 1'b1;
               hold_started_in = 1'b0;
               wait_release_in = 1'b1;
            end
         end else if (!item.button_pin) begin
            hold_started_in = 1'b0;
            wait_release_in = 1'b0;
         end
         if (tx_count_in > tx_period_ff) begin
            tx_req      = 1'b1;
            tx_count_in = 16'd0;
         end
      end else if (item.frame_id == dcsm_pkg::ID_RELAY) begin
         // Relay frame: restart the watchdog and latch the light if both relays are open.
         silence_count_in = 16'd0;
         if (armed_ff && !light_on_ff && !item.frame_data[10] && !item.frame_data[8]) begin
            light_on_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= dcsm_pkg::TIMEOUT_RESET;
         prelight_ff  <= dcsm_pkg::PRELIGHT_RESET;
         hold_ms_ff   <= dcsm_pkg::HOLD_RESET;
         tx_period_ff <= dcsm_pkg::TX_PERIOD_RESET;
      end else if (csr.we) begin
         unique case (csr.index)
            dcsm_pkg::CSR_TIMEOUT:   timeout_ff   <= csr.data;
            dcsm_pkg::CSR_PRELIGHT:  prelight_ff  <= csr.data;
            dcsm_pkg::CSR_HOLD:      hold_ms_ff   <= csr.data;
            dcsm_pkg::CSR_TX_PERIOD: tx_period_ff <= csr.data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff          <= 1'b0;
         light_on_ff       <= 1'b1;
         prelight_count_ff <= 16'd0;
         silence_count_ff  <= 16'd0;
         tx_count_ff       <= 16'd0;
         hold_count_ff     <= 16'd0;
         hold_started_ff   <= 1'b0;
         wait_release_ff   <= 1'b0;
         toggle_ff         <= 1'b0;
         rtd_ff            <= 1'b0;
      end else if (step) begin
         armed_ff          <= armed_in;
         light_on_ff       <= light_on_in;
         prelight_count_ff <= prelight_count_in;
         silence_count_ff  <= silence_count_in;
         tx_count_ff       <= tx_count_in;
         hold_count_ff     <= hold_count_in;
         hold_started_ff   <= hold_started_in;
         wait_release_ff   <= wait_release_in;
         toggle_ff         <= toggle_in;
         rtd_ff            <= rtd_in;
      end
   end

   always_comb begin
      safety.fault_light   = light_on_in;
      safety.rtd_state     = rtd_in;
      safety.button_toggle = toggle_in;
      safety.tx_request    = tx_req;
      safety.hold_started  = hold_started_in;
   end

   `DCSM_ASSERT_RST(a_armed_sticks, clock, reset, armed_ff |=> armed_ff, "light disarmed after arming")
   `DCSM_ASSERT_RST(a_fault_latches, clock, reset, (armed_ff && light_on_ff) |=> light_on_ff, "latched fault light cleared")
   `DCSM_ASSERT_RST(a_hold_or_wait, clock, reset, !(hold_started_ff && wait_release_ff), "hold and release wait both set")

endmodule

/* hw/rtl/dash_can_safety_monitor.sv */
// Top level of the dashboard CAN safety monitor: input and result registers around the logic.
//
// Request channel (req_valid, req_stall, req_item): each item is either a decoded
// CAN frame or a one millisecond tick carrying the ready-to-drive and button pin
// samples. Result channel (rsp_valid, rsp_stall, rsp_item): exactly one result per
// item, in order, holding the light, switch, button, transmit and telemetry fields.
// Settings are written through csr_we, csr_index and csr_wdata; the user must do so only
// while the block is idle, which the block does not enforce. An accepted item sits in the
// input register while the frame dispatch and tick rules update the state; its result is
// loaded into the result register once that is empty or not stalled. One item per cycle is
// sustained while the receiver does not stall, set by one pass through the update logic.
// When the receiver stalls, the result register holds; one further item waits in
// the input register and then req_stall rises until the result is taken.
// Synchronous reset turns the fault light on, clears all counters and flags,
// restores the default settings and telemetry, and empties both registers.
`timescale 1ns / 1ps
`include "dash_can_safety_monitor_assert.svh"
module dash_can_safety_monitor (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  dcsm_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output dcsm_pkg::rsp_item_type rsp_item,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [15:0]           csr_wdata
);

   logic                   s1_valid_ff, s1_valid_in;
   dcsm_pkg::req_item_type s1_item_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   dcsm_pkg::rsp_item_type rsp_item_ff, rsp_item_in;

   logic                     advance;
   logic                     load_s1;
   dcsm_pkg::csr_write_type  csr;
   dcsm_pkg::telem_out_type  telem;
   dcsm_pkg::safety_out_type safety;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign load_s1   = req_valid && !req_stall;

   assign s1_valid_in  = load_s1 | (s1_valid_ff & ~advance);
   assign rsp_valid_in = advance | (rsp_valid_ff & rsp_stall);

   always_comb begin
      csr.we    = csr_we;
      csr.index = csr_index;
      csr.data  = csr_wdata;
   end

   dcsm_telemetry u_telemetry (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .item  (s1_item_ff),
      .telem (telem)
   );

   dcsm_safety u_safety (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (s1_item_ff),
      .csr    (csr),
      .safety (safety)
   );

   always_comb begin
      rsp_item_in.fault_light       = safety.fault_light;
      rsp_item_in.rtd_state         = safety.rtd_state;
      rsp_item_in.button_toggle     = safety.button_toggle;
      rsp_item_in.tx_request        = safety.tx_request;
      if (telem.status_fault) begin
         rsp_item_in.screen_select = dcsm_pkg::SCREEN_FAULT;
      end else if (safety.hold_started && telem.precharge_on) begin
         rsp_item_in.screen_select = dcsm_pkg::SCREEN_IGNITION;
      end else begin
         rsp_item_in.screen_select = dcsm_pkg::SCREEN_NORMAL;
      end
      rsp_item_in.precharge_on      = telem.precharge_on;
      rsp_item_in.logging_on        = telem.logging_on;
      rsp_item_in.pack_temp         = telem.pack_temp;
      rsp_item_in.pack_charge       = telem.pack_charge;
      rsp_item_in.max_motor_temp    = telem.max_motor_temp;
      rsp_item_in.min_motor_voltage = telem.min_motor_voltage;
      rsp_item_in.discharge_limit   = telem.discharge_limit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_s1) begin
         s1_item_ff <= req_item;
      end
      if (advance) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   `DCSM_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> (!s1_valid_ff && !rsp_valid_ff), "registers not empty after reset")
   `DCSM_ASSERT_RST(a_advance_fills, clock, reset, advance |=> rsp_valid_ff, "result lost after advance")

endmodule
